// ===== hw/rtl/psbs_pkg.sv =====
package psbs_pkg;

	// field widths
	localparam int PRICE_W    = 24;
	localparam int SPREAD_W   = PRICE_W + 1;
	localparam int SUM_W      = 27;
	localparam int COUNT_W    = 16;
	localparam int BW_W       = 8;
	localparam int SIG_W      = 2;

	// stream payloads, packed from the lowest bit, padded to whole bytes
	localparam int IN_DATA_W  = 48;
	localparam int OUT_USED_W = SIG_W + COUNT_W + SUM_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = BW_W;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SPREAD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH     = 1'd1;
	localparam logic [BW_W-1:0]      BAND_WIDTH_RST     = 8'd32;

	// split point of the band product
	localparam int KV_SPLIT   = 32;

	// default window lengths
	localparam int MA_LEN_DEF = 3;
	localparam int BB_LEN_DEF = 20;

	typedef enum logic [SIG_W-1:0] {
		SIG_NONE  = 2'd0,
		SIG_LONG  = 2'd1,
		SIG_SHORT = 2'd2
	} entry_sig_t;

endpackage

// ===== hw/rtl/pair_spread_bollinger_signal_core.sv =====
// pair spread bollinger-band entry signal
//
// input stream: one request per tick, s_axis_tdata carries the two prices
// of the pair. output stream: one result per request, m_axis_tdata carries
// the entry signal, the running count of signals and the moving sum of the
// spread. configuration: cfg_we / cfg_index / cfg_data, written while idle.
//
// one request is in flight at a time. while fewer than BB_LEN ticks have
// been seen a request passes the update and square states and its result is
// registered in the output state; once the band is live the variance and band
// products add six steps of the shared multiply sequencer (mul, sum, var, kv,
// kvsum, cmp) before the output state. the ring of moving sums sits in a
// synchronous memory read the cycle before its write-back at the same slot.
//
// reset clears the sequencer, the running sums, the spread history and the
// per-slot valid bits of the ring, so slots never written read as zero; no
// clearing pass is needed. a stalled receiver holds the result in the output
// register; the next request is still taken and waits at the end of its
// sequence until the output register frees up.
module pair_spread_bollinger_signal_core #(
	parameter int MA_LEN = psbs_pkg::MA_LEN_DEF,
	parameter int BB_LEN = psbs_pkg::BB_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// price_first [23:0], price_second [47:24]
	input  logic [psbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// signal [1:0], entry_number [17:2], spread_window_sum [44:18], zero pad
	output logic [psbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic                             cfg_we,
	input  logic [psbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import psbs_pkg::*;

	// derived widths
	localparam int PTR_W   = $clog2(BB_LEN);
	localparam int LOG_N   = $clog2(BB_LEN);
	localparam int TK_W    = $clog2(BB_LEN + MA_LEN + 1);
	localparam int HSUM_W  = SPREAD_W + $clog2(MA_LEN);
	localparam int WIDE_W  = SUM_W + 2;
	localparam int SQ_W    = 2 * SUM_W;
	localparam int T_W     = SUM_W + 1 + LOG_N;
	localparam int DIFF_W  = T_W + 1;
	localparam int DM_W    = T_W;
	localparam int H_W     = (DM_W + 1) / 2;
	localparam int L_W     = DM_W - H_W;
	localparam int PLO_W   = DM_W + H_W;
	localparam int PHI_W   = DM_W + L_W;
	localparam int D2_W    = 2 * DM_W + 8;
	localparam int T2_W    = 2 * DM_W;
	localparam int Q_W     = SQ_W + LOG_N;
	localparam int NQ_W    = Q_W + LOG_N + 1;
	localparam int SUB_W   = (NQ_W > T2_W) ? NQ_W : T2_W;
	localparam int V_W     = NQ_W;
	localparam int K2_W    = 2 * BW_W;
	localparam int KVL_W   = KV_SPLIT + K2_W;
	localparam int KVH_W   = V_W - KV_SPLIT + K2_W;
	localparam int KV_W    = V_W + K2_W;
	localparam int CMP_W   = (D2_W > KV_W) ? D2_W : KV_W;

	localparam logic [TK_W-1:0]          TICK_CAP  = TK_W'(BB_LEN + MA_LEN);
	localparam logic [TK_W-1:0]          TICK_MA   = TK_W'(MA_LEN - 1);
	localparam logic [TK_W-1:0]          TICK_BB   = TK_W'(BB_LEN);
	localparam logic [PTR_W-1:0]         PTR_LAST  = PTR_W'(BB_LEN - 1);
	localparam logic signed [WIDE_W-1:0] SUM_MAX_W = WIDE_W'(2 ** (SUM_W - 1) - 1);
	localparam logic signed [WIDE_W-1:0] SUM_MIN_W = -WIDE_W'(2 ** (SUM_W - 1));
	localparam logic signed [T_W-1:0]    BB_LEN_T  = T_W'(BB_LEN);
	localparam logic [NQ_W-1:0]          BB_LEN_NQ = NQ_W'(BB_LEN);
	localparam logic [COUNT_W-1:0]       COUNT_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SQUARE,
		ST_MUL,
		ST_SUM,
		ST_VAR,
		ST_KV,
		ST_KVSUM,
		ST_CMP,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic            reverse_q;
	logic [BW_W-1:0] band_width_q;

	// spread history and its running sum
	logic signed [SPREAD_W-1:0] hist_q [MA_LEN];
	logic signed [HSUM_W-1:0]   hist_sum_q;

	// ring of moving sums
	logic signed [SUM_W-1:0] ring_mem [BB_LEN];
	logic signed [SUM_W-1:0] ring_rd_q;
	logic [BB_LEN-1:0]       ring_valid_q;
	logic [PTR_W-1:0]        pos_q;

	// window statistics and counters
	logic signed [T_W-1:0] total_q;
	logic [Q_W-1:0]        sq_total_q;
	logic [TK_W-1:0]       ticks_q;
	logic [COUNT_W-1:0]    entries_q;

	// sequencer pipeline
	logic signed [SUM_W-1:0] x_s1;
	logic [TK_W-1:0]         tick_s1;
	logic [SQ_W-1:0]         old_sq_s2;
	logic [SQ_W-1:0]         x_sq_s2;
	logic signed [T_W-1:0]   nx_s2;
	logic [DM_W-1:0]         dmag_s3;
	logic [DM_W-1:0]         tmag_s3;
	logic                    dneg_s3;
	logic                    dzero_s3;
	logic [PLO_W-1:0]        dp_lo_s4;
	logic [PHI_W-1:0]        dp_hi_s4;
	logic [PLO_W-1:0]        tp_lo_s4;
	logic [PHI_W-1:0]        tp_hi_s4;
	logic [NQ_W-1:0]         nq_s4;
	logic [D2_W-1:0]         d2_s5;
	logic [T2_W-1:0]         t2_s5;
	logic [V_W-1:0]          v_s6;
	logic [KVL_W-1:0]        kv_lo_s7;
	logic [KVH_W-1:0]        kv_hi_s7;
	logic [KV_W-1:0]         kv_s8;
	entry_sig_t              sig_s9;

	// output register
	logic                    out_valid_q;
	entry_sig_t              out_sig_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic signed [SUM_W-1:0] out_sum_q;

	// combinational datapath
	logic [PRICE_W-1:0]         price_first;
	logic [PRICE_W-1:0]         price_second;
	logic signed [SPREAD_W-1:0] spread;
	logic signed [HSUM_W-1:0]   hist_sum_next;
	logic signed [WIDE_W-1:0]   sum_wide;
	logic signed [SUM_W-1:0]    sum_sat;
	logic signed [SUM_W-1:0]    x_next;
	logic signed [SUM_W-1:0]    old_val;
	logic [SUM_W-1:0]           old_mag;
	logic [SUM_W-1:0]           x_mag;
	logic signed [DIFF_W-1:0]   diff;
	logic [K2_W-1:0]            k2;
	logic                       beyond;
	logic                       in_take;
	logic                       out_free;
	logic [COUNT_W-1:0]         entries_next;

	assign price_first  = s_axis_tdata[PRICE_W-1:0];
	assign price_second = s_axis_tdata[2*PRICE_W-1:PRICE_W];
	assign in_take      = s_axis_tvalid && s_axis_tready;
	assign out_free     = !out_valid_q || m_axis_tready;

	always_comb begin
		// spread in the configured direction
		if (reverse_q) begin
			spread = signed'({1'b0, price_second}) - signed'({1'b0, price_first});
		end else begin
			spread = signed'({1'b0, price_first}) - signed'({1'b0, price_second});
		end

		// moving sum: drop the oldest spread, add the new one
		hist_sum_next = hist_sum_q - HSUM_W'(hist_q[MA_LEN-1]) + HSUM_W'(spread);
		sum_wide      = WIDE_W'(hist_sum_next);
		if (sum_wide > SUM_MAX_W) begin
			sum_sat = SUM_W'(SUM_MAX_W);
		end else if (sum_wide < SUM_MIN_W) begin
			sum_sat = SUM_W'(SUM_MIN_W);
		end else begin
			sum_sat = SUM_W'(sum_wide);
		end
		// zero while the moving window fills
		x_next = (ticks_q >= TICK_MA) ? sum_sat : '0;

		// slot never written reads as zero
		old_val = ring_valid_q[pos_q] ? ring_rd_q : '0;
		old_mag = old_val[SUM_W-1] ? SUM_W'(-old_val) : SUM_W'(old_val);
		x_mag   = x_s1[SUM_W-1] ? SUM_W'(-x_s1) : SUM_W'(x_s1);

		diff = DIFF_W'(nx_s2) - DIFF_W'(total_q);

		k2     = K2_W'(band_width_q) * K2_W'(band_width_q);
		beyond = CMP_W'(d2_s5) >= CMP_W'(kv_s8);

		entries_next = entries_q;
		if (sig_s9 != SIG_NONE && entries_q != COUNT_MAX) begin
			entries_next = entries_q + COUNT_W'(1);
		end
	end

	// ring memory: read at the current slot every cycle, written back in ST_UPDATE
	always_ff @(posedge clk) begin
		ring_rd_q <= ring_mem[pos_q];
		if (state_q == ST_UPDATE) begin
			ring_mem[pos_q] <= x_s1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_s1    <= x_next;
				tick_s1 <= ticks_q;
			end
			ST_UPDATE: begin
				old_sq_s2 <= SQ_W'(old_mag) * SQ_W'(old_mag);
				x_sq_s2   <= SQ_W'(x_mag) * SQ_W'(x_mag);
				nx_s2     <= T_W'(x_s1) * BB_LEN_T;
			end
			ST_SQUARE: begin
				dneg_s3  <= diff < 0;
				dzero_s3 <= diff == '0;
				dmag_s3  <= (diff < 0) ? DM_W'(-diff) : DM_W'(diff);
				tmag_s3  <= total_q[T_W-1] ? DM_W'(-total_q) : DM_W'(total_q);
			end
			ST_MUL: begin
				// squares as two partial products each
				dp_lo_s4 <= PLO_W'(dmag_s3) * PLO_W'(dmag_s3[H_W-1:0]);
				dp_hi_s4 <= PHI_W'(dmag_s3) * PHI_W'(dmag_s3[DM_W-1:H_W]);
				tp_lo_s4 <= PLO_W'(tmag_s3) * PLO_W'(tmag_s3[H_W-1:0]);
				tp_hi_s4 <= PHI_W'(tmag_s3) * PHI_W'(tmag_s3[DM_W-1:H_W]);
				nq_s4    <= NQ_W'(sq_total_q) * BB_LEN_NQ;
			end
			ST_SUM: begin
				// d carries a factor of 16, so its square a factor of 256
				d2_s5 <= (D2_W'(dp_hi_s4) << (H_W + 8)) + (D2_W'(dp_lo_s4) << 8);
				t2_s5 <= (T2_W'(tp_hi_s4) << H_W) + T2_W'(tp_lo_s4);
			end
			ST_VAR: begin
				v_s6 <= V_W'(SUB_W'(nq_s4) - SUB_W'(t2_s5));
			end
			ST_KV: begin
				kv_lo_s7 <= KVL_W'(v_s6[KV_SPLIT-1:0]) * KVL_W'(k2);
				kv_hi_s7 <= KVH_W'(v_s6[V_W-1:KV_SPLIT]) * KVH_W'(k2);
			end
			ST_KVSUM: begin
				kv_s8 <= (KV_W'(kv_hi_s7) << KV_SPLIT) + KV_W'(kv_lo_s7);
			end
			ST_CMP, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer, window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			reverse_q    <= 1'b0;
			band_width_q <= BAND_WIDTH_RST;
			for (int i = 0; i < MA_LEN; i++) begin
				hist_q[i] <= '0;
			end
			hist_sum_q   <= '0;
			ring_valid_q <= '0;
			pos_q        <= '0;
			total_q      <= '0;
			sq_total_q   <= '0;
			ticks_q      <= '0;
			entries_q    <= '0;
			sig_s9       <= SIG_NONE;
			out_valid_q  <= 1'b0;
			out_sig_q    <= SIG_NONE;
			out_count_q  <= '0;
			out_sum_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_REVERSE_SPREAD: reverse_q    <= cfg_data[0];
					REG_BAND_WIDTH:     band_width_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// a new result takes the register, else a taken result leaves it
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						for (int i = MA_LEN - 1; i > 0; i--) begin
							hist_q[i] <= hist_q[i-1];
						end
						hist_q[0]  <= spread;
						hist_sum_q <= hist_sum_next;
						if (ticks_q < TICK_CAP) begin
							ticks_q <= ticks_q + TK_W'(1);
						end
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					total_q             <= total_q - T_W'(old_val) + T_W'(x_s1);
					ring_valid_q[pos_q] <= 1'b1;
					pos_q               <= (pos_q == PTR_LAST) ? '0 : pos_q + PTR_W'(1);
					state_q             <= ST_SQUARE;
				end
				ST_SQUARE: begin
					sq_total_q <= sq_total_q + Q_W'(x_sq_s2) - Q_W'(old_sq_s2);
					if (tick_s1 < TICK_BB) begin
						sig_s9  <= SIG_NONE;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_VAR;
				ST_VAR:   state_q <= ST_KV;
				ST_KV:    state_q <= ST_KVSUM;
				ST_KVSUM: state_q <= ST_CMP;
				ST_CMP: begin
					// long wins when d is zero and the band has collapsed
					if (beyond && (dneg_s3 || dzero_s3)) begin
						sig_s9 <= SIG_LONG;
					end else if (beyond) begin
						sig_s9 <= SIG_SHORT;
					end else begin
						sig_s9 <= SIG_NONE;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						entries_q   <= entries_next;
						out_sig_q   <= sig_s9;
						out_count_q <= entries_next;
						out_sum_q   <= x_s1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_sum_q, out_count_q, out_sig_q};

endmodule

// ===== sim/psbs_band_checker.sv =====
`timescale 1ns / 100ps

module psbs_band_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	// price_first [23:0], price_second [47:24]
	input  logic [psbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	// signal [1:0], entry_number [17:2], spread_window_sum [44:18], zero pad
	input  logic [psbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic                              cfg_we,
	input  logic [psbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                fail_count,
	output int                                pending
);

	localparam int MA = psbs_pkg::MA_LEN_DEF;
	localparam int BB = psbs_pkg::BB_LEN_DEF;
	localparam int PW = psbs_pkg::PRICE_W;
	localparam int SW = psbs_pkg::SUM_W;
	localparam int CW = psbs_pkg::COUNT_W;
	localparam int SLOT_W = $clog2(BB);
	localparam longint SUM_TOP = (longint'(1) << (SW - 1)) - 1;
	localparam longint SUM_BOT = -SUM_TOP - 1;

	typedef struct packed {
		psbs_pkg::entry_sig_t   sig;
		logic [CW-1:0]          number;
		logic signed [SW-1:0]   sum;
	} entry_result_t;

	// shadow of the block state
	logic                               rev_cfg;
	logic [psbs_pkg::BW_W-1:0]          band_cfg;
	logic signed [psbs_pkg::SPREAD_W-1:0] spread_hist [MA];
	logic signed [SW-1:0]               sum_ring [BB];
	logic [SLOT_W-1:0]                  ring_slot;
	int unsigned                        tick_count;
	longint                             win_total;
	longint                             win_sq_total;
	logic [CW-1:0]                      sig_tally;

	entry_result_t band_results [$];
	int unsigned   results_seen;

	function automatic entry_result_t advance_band_tick(input logic [PW-1:0] pf,
			input logic [PW-1:0] ps);
		logic signed [PW:0]    spr;
		longint                acc;
		longint                old_sum;
		logic signed [127:0]   tot, sq, dev, dev_sq, spread_var, k_sq;
		logic                  beyond;
		psbs_pkg::entry_sig_t  sig;
		entry_result_t         res;

		spr = rev_cfg ? $signed({1'b0, ps}) - $signed({1'b0, pf})
		              : $signed({1'b0, pf}) - $signed({1'b0, ps});
		for (int i = MA - 1; i > 0; i--)
			spread_hist[i] = spread_hist[i-1];
		spread_hist[0] = spr;

		// moving sum stays zero until the spread window has filled
		acc = 0;
		if (tick_count >= MA - 1) begin
			for (int i = 0; i < MA; i++)
				acc += spread_hist[i];
			if (acc > SUM_TOP)
				acc = SUM_TOP;
			if (acc < SUM_BOT)
				acc = SUM_BOT;
		end

		old_sum = sum_ring[ring_slot];
		win_total = win_total - old_sum + acc;
		win_sq_total = win_sq_total - old_sum * old_sum + acc * acc;
		sum_ring[ring_slot] = acc[SW-1:0];
		ring_slot = (ring_slot == SLOT_W'(BB - 1)) ? '0 : ring_slot + 1'b1;

		sig = psbs_pkg::SIG_NONE;
		if (tick_count >= BB) begin
			tot = win_total;
			sq = win_sq_total;
			dev = 16 * (BB * acc - tot);
			dev_sq = dev * dev;
			spread_var = BB * sq - tot * tot;
			k_sq = band_cfg * band_cfg;
			beyond = dev_sq >= k_sq * spread_var;
			if (dev <= 0 && beyond)
				sig = psbs_pkg::SIG_LONG;
			else if (dev >= 0 && beyond)
				sig = psbs_pkg::SIG_SHORT;
		end

		if (sig != psbs_pkg::SIG_NONE && sig_tally != '1)
			sig_tally++;
		if (tick_count < BB + MA)
			tick_count++;

		res.sig = sig;
		res.number = sig_tally;
		res.sum = acc[SW-1:0];
		return res;
	endfunction

	task automatic check_result(input logic [psbs_pkg::OUT_DATA_W-1:0] word);
		entry_result_t         want;
		logic [1:0]            got_sig;
		logic [CW-1:0]         got_num;
		logic signed [SW-1:0]  got_sum;

		got_sig = word[1:0];
		got_num = word[17:2];
		got_sum = word[44:18];
		if (band_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result with no request outstanding, data %h", $time, word);
		end else begin
			want = band_results.pop_front();
			if (got_sig !== want.sig || got_num !== want.number || got_sum !== want.sum) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result %0d expected sig %0d cnt %0d sum %0d, got sig %0d cnt %0d sum %0d",
						$time, results_seen, want.sig, want.number, want.sum,
						got_sig, got_num, got_sum);
			end
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_cfg = 1'b0;
			band_cfg = psbs_pkg::BAND_WIDTH_RST;
			for (int i = 0; i < MA; i++)
				spread_hist[i] = '0;
			for (int i = 0; i < BB; i++)
				sum_ring[i] = '0;
			ring_slot = '0;
			tick_count = 0;
			win_total = 0;
			win_sq_total = 0;
			sig_tally = '0;
			band_results.delete();
			results_seen = 0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (cfg_we) begin
				case (cfg_index)
					psbs_pkg::REG_REVERSE_SPREAD: rev_cfg = cfg_data[0];
					psbs_pkg::REG_BAND_WIDTH:     band_cfg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				band_results = {band_results, advance_band_tick(s_axis_tdata[PW-1:0],
					s_axis_tdata[2*PW-1:PW])};
			pending <= band_results.size();
		end
	end

endmodule

// ===== sim/pair_spread_bollinger_signal_core_tb.sv =====
`timescale 1ns / 100ps

module pair_spread_bollinger_signal_core_tb;

	localparam int PW          = psbs_pkg::PRICE_W;
	localparam int PRICE_TOP   = (1 << PW) - 1;
	// no accepted request, result or write for this long means the block hung
	localparam int STUCK_LIMIT = 3000;
	// receiver hold-off, long enough to back the block up into its input
	localparam int HOLD_CYCLES = 400;
	// drain margin at the end
	localparam int TAIL_CYCLES = 20;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	// price_first [23:0], price_second [47:24]
	logic [psbs_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	// signal [1:0], entry_number [17:2], spread_window_sum [44:18], zero pad
	logic [psbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [psbs_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [psbs_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

	int fail_count;
	int pending;

	// idling is switched off on both sides while steady is high
	logic steady = 1'b0;
	// each bump asks the receiver process for one long hold-off
	int   hold_asks = 0;
	int   stuck_cycles = 0;

	// random-walk state of the two prices
	int walk_first;
	int walk_second;

	always #5 clk = ~clk;

	pair_spread_bollinger_signal_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	psbs_band_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	function automatic int clamp_price(input int p);
		if (p < 0)
			return 0;
		if (p > PRICE_TOP)
			return PRICE_TOP;
		return p;
	endfunction

	// offer one request, with a random gap in front of it unless steady
	task automatic send_tick(input logic [PW-1:0] pf, input logic [PW-1:0] ps);
		while (!steady && $urandom_range(99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ps, pf};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// stop offering and wait until every outstanding result has been taken
	task automatic wait_drained;
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// both registers in back-to-back writes, only ever called with the block idle
	task automatic set_band(input logic reverse, input logic [psbs_pkg::BW_W-1:0] width);
		cfg_we <= 1'b1;
		cfg_index <= psbs_pkg::REG_REVERSE_SPREAD;
		cfg_data <= {{(psbs_pkg::CFG_DATA_W-1){1'b0}}, reverse};
		@(posedge clk);
		cfg_index <= psbs_pkg::REG_BAND_WIDTH;
		cfg_data <= width;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly a correlated random walk so the band statistics settle and get crossed,
	// with the odd spike on the first leg and some requests of pure noise
	task automatic wander_pair(output logic [PW-1:0] pf, output logic [PW-1:0] ps);
		int roll;
		int step;

		roll = $urandom_range(99);
		if (roll < 12) begin
			pf = PW'($urandom_range(PRICE_TOP));
			ps = PW'($urandom_range(PRICE_TOP));
		end else begin
			step = int'($urandom_range(192)) - 96;
			walk_second = clamp_price(walk_second + step + int'($urandom_range(96)) - 48);
			if (roll < 18)
				step += int'($urandom_range(1 << 21)) - (1 << 20);
			walk_first = clamp_price(walk_first + step);
			pf = walk_first[PW-1:0];
			ps = walk_second[PW-1:0];
		end
	endtask

	task automatic run_walk(input int count);
		logic [PW-1:0] pf;
		logic [PW-1:0] ps;

		walk_first = $urandom_range(PRICE_TOP);
		walk_second = clamp_price(walk_first + int'($urandom_range(8192)) - 4096);
		repeat (count) begin
			wander_pair(pf, ps);
			send_tick(pf, ps);
		end
	endtask

	// receiver: random stalls, or a long counted hold-off when asked for one
	initial begin
		int hold_left;
		int hold_seen;

		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else
				m_axis_tready <= steady || $urandom_range(99) >= 13;
		end
	end

	// watchdog on forward progress
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we)
			stuck_cycles <= 0;
		else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("[pair_spread_bollinger_signal_core] ERROR");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings: price extremes and checkerboards,
		// then a flat stretch to fill the band and sharp swings either way
		send_tick(24'hFFFFFF, 24'h000000);
		send_tick(24'h000000, 24'hFFFFFF);
		send_tick(24'hFFFFFF, 24'hFFFFFF);
		send_tick(24'h000000, 24'h000000);
		send_tick(24'hAAAAAA, 24'h555555);
		send_tick(24'h555555, 24'hAAAAAA);
		repeat (15)
			send_tick(24'd1000, 24'd1000);
		// spread jumps up, short expected once the band is live
		send_tick(24'hFFFFFF, 24'h000000);
		// and swings down hard, long expected
		send_tick(24'h000000, 24'hFFFFFF);
		send_tick(24'h000000, 24'hFFFFFF);
		send_tick(24'd1000, 24'd1000);
		wait_drained;

		// reversed spread, zero band so every live tick fires; the receiver
		// holds off for a long stretch while requests keep coming
		set_band(1'b1, 8'd0);
		hold_asks <= hold_asks + 1;
		run_walk(120);
		wait_drained;

		// widest band, no idling on either side
		set_band(1'b0, 8'd255);
		steady <= 1'b1;
		run_walk(120);
		wait_drained;
		steady <= 1'b0;

		// narrow band; the sender pauses midway until everything has come back
		set_band(1'b1, 8'd8);
		run_walk(50);
		wait_drained;
		run_walk(70);
		wait_drained;

		set_band(1'b0, 8'd16);
		run_walk(120);
		wait_drained;

		set_band(1'b1, 8'd255);
		run_walk(70);
		wait_drained;

		// back to the reset band
		set_band(1'b0, psbs_pkg::BAND_WIDTH_RST);
		run_walk(75);
		wait_drained;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[pair_spread_bollinger_signal_core] OK");
		else
			$display("[pair_spread_bollinger_signal_core] ERROR");
		$finish;
	end

endmodule
